// File: rtl/fca_pkg.sv
// Shared types and constants of the allocation table chain allocator.
// Used by fca_div, fat_chain_allocator and fca_chk; depends on nothing.
`default_nettype none

package fca_pkg;

  localparam int unsigned MAX_BLOCKS = 256;
  localparam int unsigned IDX_W      = 8;   // table address
  localparam int unsigned PTR_W      = 9;   // table entry, pointer, free count
  localparam int unsigned LEN_W      = 12;  // allocation length in bytes
  localparam int unsigned BB_W       = 7;   // bytes per block
  localparam int unsigned CFG_W      = 9;   // configuration write data

  localparam logic [PTR_W-1:0] END_CODE  = PTR_W'(MAX_BLOCKS);
  localparam logic [PTR_W-1:0] FREE_CODE = PTR_W'(MAX_BLOCKS + 1);

  // Configuration register indexes
  localparam logic REG_BLOCK_BYTES   = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_RANGE    = 2'd2
  } status_e;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] dividend;
    logic [BB_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] quot;
    logic             rem_nz;
  } div_res_t;

endpackage

`default_nettype wire

// File: rtl/fca_div.sv
// Restoring divider, one quotient bit per cycle: length / bytes per block.
// Depends on fca_pkg for widths and the request/result structs.
`default_nettype none

module fca_div (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  fca_pkg::div_req_t     req_i,
  output fca_pkg::div_res_t     res_o
);

  localparam int unsigned CNT_W = $clog2(fca_pkg::LEN_W);

  logic                          busy_q;
  logic                          done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [fca_pkg::LEN_W-1:0]     num_q;
  logic [fca_pkg::BB_W-1:0]      rem_q;
  logic [fca_pkg::BB_W-1:0]      div_q;

  logic [fca_pkg::BB_W:0]        shifted;
  logic [fca_pkg::BB_W:0]        diff;
  logic                          ge;
  logic [fca_pkg::BB_W-1:0]      rem_d;

  always_comb begin
    shifted = {rem_q, num_q[fca_pkg::LEN_W-1]};
    ge      = shifted >= {1'b0, div_q};
    diff    = shifted - {1'b0, div_q};
    rem_d   = ge ? diff[fca_pkg::BB_W-1:0] : shifted[fca_pkg::BB_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(fca_pkg::LEN_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

  // Datapath: shift the dividend out, the quotient in
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      div_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[fca_pkg::LEN_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign res_o.done   = done_q;
  assign res_o.quot   = num_q;
  assign res_o.rem_nz = |rem_q;

endmodule

`default_nettype wire

// File: rtl/fat_chain_allocator.sv
// Top level of the allocation table chain allocator: table memory and sequencer.
// Depends on fca_pkg and fca_div.
`default_nettype none

// One request is handled at a time; the next is taken in the cycle after its
// result is loaded into the output register. A lookup reads the entry, takes
// the read data in S_LOOK and then answers. A zero length, an index out of
// range or an unused kind goes straight to the answer state. A free walks the
// chain and halts at its end, or on an entry that is already free. An allocate
// runs the bit-serial division of the length, then a space check (a no-space
// answer leaves here), then a scan that reads one entry per cycle through the
// single read port of the table memory and stops at the last block it needs,
// then closes the chain. The free walk follows one link per cycle. A result
// that the receiver holds off stalls the next result in the sequencer, and
// with it the input. Writing blocks_in_use empties the table at once through
// per-entry valid bits, so no clearing pass is needed; an entry never written
// since reads as free. Configuration is taken only while idle, and a waiting
// register write holds requests back.

module fat_chain_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request: tdata = length_bytes[11:0], block_index[19:12], zero pad
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,   // kind
  // result: tdata = pointer[8:0], free_blocks[17:9], zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,   // status
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [8:0]  cfg_data_i
);

  localparam int unsigned PW = fca_pkg::PTR_W;
  localparam int unsigned IW = fca_pkg::IDX_W;
  localparam int unsigned LW = fca_pkg::LEN_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_CHECK, S_SCAN, S_LINK, S_WALK, S_LOOK, S_RESP
  } state_e;

  state_e                    state_q, state_d;
  logic [fca_pkg::BB_W-1:0]  bb_q, bb_d;
  logic [PW-1:0]             used_q, used_d;
  logic [PW-1:0]             free_cnt_q, free_cnt_d;
  logic [LW-1:0]             need_q, need_d;
  logic [PW-1:0]             scan_q, scan_d;
  logic [IW-1:0]             chk_addr_q, chk_addr_d;
  logic                      pend_q, pend_d;
  logic [IW-1:0]             prev_q, prev_d;
  logic                      have_prev_q, have_prev_d;
  logic [PW-1:0]             taken_q, taken_d;
  logic [IW-1:0]             cur_q, cur_d;
  logic [PW-1:0]             steps_q, steps_d;
  fca_pkg::status_e          res_status_q, res_status_d;
  logic [PW-1:0]             res_ptr_q, res_ptr_d;
  logic                      m_valid_q, m_valid_d;
  fca_pkg::status_e          m_status_q, m_status_d;
  logic [PW-1:0]             m_ptr_q, m_ptr_d;
  logic [PW-1:0]             m_free_q, m_free_d;

  // Table memory and its per-entry valid bits
  logic [PW-1:0]             mem [fca_pkg::MAX_BLOCKS];
  logic [fca_pkg::MAX_BLOCKS-1:0] valid_q;
  logic [PW-1:0]             rd_data_q;
  logic                      rd_vld_q;
  logic                      fwd_q;
  logic [PW-1:0]             fwd_data_q;
  logic                      rd_en;
  logic [IW-1:0]             rd_addr;
  logic                      we;
  logic [IW-1:0]             wa;
  logic [PW-1:0]             wd;
  logic                      clear_tbl;
  logic [PW-1:0]             rd_eff;

  fca_pkg::div_req_t         div_req;
  fca_pkg::div_res_t         div_res;

  logic                      in_acc;
  logic                      cfg_acc;
  logic [LW-1:0]             in_len;
  logic [IW-1:0]             in_idx;
  logic [fca_pkg::BB_W-1:0]  bb_eff;
  logic [PW-1:0]             used_sat;
  logic [PW-1:0]             taken_inc;
  logic                      found;

  fca_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  // Hold requests back while a register write waits
  assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign in_len        = s_axis_tdata[11:0];
  assign in_idx        = s_axis_tdata[19:12];
  assign bb_eff        = (bb_q == '0) ? fca_pkg::BB_W'(1) : bb_q;
  assign used_sat      = (cfg_data_i > PW'(fca_pkg::MAX_BLOCKS)) ?
                         PW'(fca_pkg::MAX_BLOCKS) : cfg_data_i;
  assign taken_inc     = taken_q + PW'(1);

  // Same-cycle write wins; an entry never written reads as free
  assign rd_eff = fwd_q ? fwd_data_q : (rd_vld_q ? rd_data_q : fca_pkg::FREE_CODE);
  assign found  = pend_q && (rd_eff == fca_pkg::FREE_CODE);

  always_comb begin
    state_d      = state_q;
    bb_d         = bb_q;
    used_d       = used_q;
    free_cnt_d   = free_cnt_q;
    need_d       = need_q;
    scan_d       = scan_q;
    chk_addr_d   = chk_addr_q;
    pend_d       = pend_q;
    prev_d       = prev_q;
    have_prev_d  = have_prev_q;
    taken_d      = taken_q;
    cur_d        = cur_q;
    steps_d      = steps_q;
    res_status_d = res_status_q;
    res_ptr_d    = res_ptr_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_status_d   = m_status_q;
    m_ptr_d      = m_ptr_q;
    m_free_d     = m_free_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    we           = 1'b0;
    wa           = '0;
    wd           = fca_pkg::FREE_CODE;
    clear_tbl    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = in_len;
    div_req.divisor  = bb_eff;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_status_d = fca_pkg::STAT_OK;
          res_ptr_d    = fca_pkg::END_CODE;
          case (fca_pkg::kind_e'(s_axis_tuser))
            fca_pkg::KIND_ALLOC: begin
              if (in_len == '0) begin
                state_d = S_RESP;
              end else begin
                div_req.start = 1'b1;
                state_d       = S_DIV;
              end
            end
            fca_pkg::KIND_FREE, fca_pkg::KIND_LOOKUP: begin
              if ({1'b0, in_idx} >= used_q) begin
                res_status_d = fca_pkg::STAT_RANGE;
                state_d      = S_RESP;
              end else begin
                rd_en   = 1'b1;
                rd_addr = in_idx;
                cur_d   = in_idx;
                steps_d = '0;
                state_d = (s_axis_tuser == fca_pkg::KIND_FREE) ? S_WALK : S_LOOK;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end

      S_DIV: begin
        if (div_res.done) begin
          need_d  = div_res.quot + LW'(div_res.rem_nz);
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        if (need_q > LW'(free_cnt_q)) begin
          res_status_d = fca_pkg::STAT_NO_SPACE;
          state_d      = S_RESP;
        end else begin
          scan_d      = '0;
          pend_d      = 1'b0;
          taken_d     = '0;
          have_prev_d = 1'b0;
          state_d     = S_SCAN;
        end
      end

      S_SCAN: begin
        // Link each free entry found to the one before it
        if (found) begin
          if (have_prev_q) begin
            we = 1'b1;
            wa = prev_q;
            wd = {1'b0, chk_addr_q};
          end else begin
            res_ptr_d = {1'b0, chk_addr_q};
          end
          prev_d      = chk_addr_q;
          have_prev_d = 1'b1;
          taken_d     = taken_inc;
        end
        if ((found && LW'(taken_inc) == need_q) || (!pend_q && scan_q >= used_q)) begin
          pend_d  = 1'b0;
          state_d = S_LINK;
        end else if (scan_q < used_q) begin
          rd_en      = 1'b1;
          rd_addr    = scan_q[IW-1:0];
          chk_addr_d = scan_q[IW-1:0];
          pend_d     = 1'b1;
          scan_d     = scan_q + PW'(1);
        end else begin
          pend_d = 1'b0;
        end
      end

      S_LINK: begin
        if (have_prev_q) begin
          we = 1'b1;
          wa = prev_q;
          wd = fca_pkg::END_CODE;
        end
        free_cnt_d = free_cnt_q - taken_q;
        state_d    = S_RESP;
      end

      S_WALK: begin
        if (rd_eff == fca_pkg::FREE_CODE) begin
          state_d = S_RESP;
        end else begin
          we         = 1'b1;
          wa         = cur_q;
          wd         = fca_pkg::FREE_CODE;
          free_cnt_d = free_cnt_q + PW'(1);
          steps_d    = steps_q + PW'(1);
          // follow the link straight from the read data
          if (rd_eff < used_q && steps_q < PW'(fca_pkg::MAX_BLOCKS - 1)) begin
            rd_en   = 1'b1;
            rd_addr = rd_eff[IW-1:0];
            cur_d   = rd_eff[IW-1:0];
          end else begin
            state_d = S_RESP;
          end
        end
      end

      S_LOOK: begin
        res_ptr_d = rd_eff;
        state_d   = S_RESP;
      end

      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_ptr_d    = res_ptr_q;
          m_free_d   = free_cnt_q;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (cfg_acc) begin
      case (cfg_index_i)
        fca_pkg::REG_BLOCK_BYTES: bb_d = cfg_data_i[fca_pkg::BB_W-1:0];
        fca_pkg::REG_BLOCKS_IN_USE: begin
          used_d     = used_sat;
          free_cnt_d = used_sat;
          clear_tbl  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bb_q        <= fca_pkg::BB_W'(8);
      used_q      <= PW'(fca_pkg::MAX_BLOCKS);
      free_cnt_q  <= PW'(fca_pkg::MAX_BLOCKS);
      pend_q      <= 1'b0;
      have_prev_q <= 1'b0;
      m_valid_q   <= 1'b0;
      m_status_q  <= fca_pkg::STAT_OK;
      m_ptr_q     <= fca_pkg::END_CODE;
      m_free_q    <= '0;
      valid_q     <= '0;
      fwd_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      bb_q        <= bb_d;
      used_q      <= used_d;
      free_cnt_q  <= free_cnt_d;
      pend_q      <= pend_d;
      have_prev_q <= have_prev_d;
      m_valid_q   <= m_valid_d;
      m_status_q  <= m_status_d;
      m_ptr_q     <= m_ptr_d;
      m_free_q    <= m_free_d;
      fwd_q       <= rd_en && we && (wa == rd_addr);
      if (clear_tbl) begin
        valid_q <= '0;
      end else if (we) begin
        valid_q[wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    need_q       <= need_d;
    scan_q       <= scan_d;
    chk_addr_q   <= chk_addr_d;
    prev_q       <= prev_d;
    taken_q      <= taken_d;
    cur_q        <= cur_d;
    steps_q      <= steps_d;
    res_status_q <= res_status_d;
    res_ptr_q    <= res_ptr_d;
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_vld_q  <= valid_q[rd_addr];
    end
    fwd_data_q <= wd;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_free_q, m_ptr_q};
  assign m_axis_tuser  = m_status_q;

endmodule

`default_nettype wire

// File: rtl/fca_chk.sv
// Port-level checks of fat_chain_allocator, bound to the top level.
// Depends on fca_pkg for codes and the table size.
`default_nettype none

module fca_sva (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        cfg_ready_o
);

  // One request at a time: the input closes after every transaction
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a request is in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Every failed request answers with end of chain
  a_err_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != fca_pkg::STAT_OK) |->
      m_axis_tdata[8:0] == fca_pkg::END_CODE)
    else $error("error result without end-of-chain pointer");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[17:9] <= 9'(fca_pkg::MAX_BLOCKS))
    else $error("free count above table size");

  // Requests are only taken in the idle window, where configuration is open too
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> cfg_ready_o)
    else $error("request ready outside idle");

endmodule

bind fat_chain_allocator fca_sva u_fca_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_ready_o   (cfg_ready_o)
);

`default_nettype wire

// File: verif/fca_chk.sv
// Checker for the allocation table chain allocator: watches the request, result and
// configuration channels, predicts every result and compares it. Depends on fca_pkg.
`timescale 1ns / 1ps

module fca_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // length_bytes[11:0], block_index[19:12]
  input  logic [1:0]  s_axis_tuser,    // kind
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,    // pointer[8:0], free_blocks[17:9]
  input  logic [1:0]  m_axis_tuser,    // status
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          results_o,
  output int          no_space_o,
  output int          range_o
);

  localparam int unsigned PW = fca_pkg::PTR_W;

  typedef struct packed {
    fca_pkg::status_e status;
    logic [PW-1:0]    pointer;
    logic [PW-1:0]    free_blocks;
  } fat_result_t;

  logic [PW-1:0]                chain_next [fca_pkg::MAX_BLOCKS];
  logic [PW-1:0]                free_left;
  logic [fca_pkg::BB_W-1:0]     bytes_per_blk;
  logic [fca_pkg::CFG_W-1:0]    table_size;
  fat_result_t                  awaited_results [$];

  int mismatches = 0;
  int outstanding = 0;
  int result_cnt = 0;
  int no_space_cnt = 0;
  int range_cnt = 0;

  assign errors_o   = mismatches;
  assign pending_o  = outstanding;
  assign results_o  = result_cnt;
  assign no_space_o = no_space_cnt;
  assign range_o    = range_cnt;

  function automatic int unsigned live_entries();
    return (table_size > fca_pkg::MAX_BLOCKS) ? fca_pkg::MAX_BLOCKS : int'(table_size);
  endfunction

  task automatic clear_chain_table();
    for (int i = 0; i < fca_pkg::MAX_BLOCKS; i++) chain_next[i] = fca_pkg::FREE_CODE;
    free_left = PW'(live_entries());
  endtask

  // Apply one request to the shadow table and work out its result.
  task automatic serve_request(input logic [1:0] kind,
                               input logic [fca_pkg::LEN_W-1:0] len,
                               input logic [fca_pkg::IDX_W-1:0] idx,
                               output fat_result_t res);
    int unsigned used, divisor, need, taken, prev, cur, steps;
    logic [PW-1:0] nxt;
    logic have_prev;
    used = live_entries();
    res.status  = fca_pkg::STAT_OK;
    res.pointer = fca_pkg::END_CODE;
    case (kind)
      fca_pkg::KIND_ALLOC: begin
        divisor = (bytes_per_blk == 0) ? 1 : int'(bytes_per_blk);
        need = (int'(len) + divisor - 1) / divisor;
        if (need != 0) begin
          if (need > free_left) begin
            res.status = fca_pkg::STAT_NO_SPACE;
          end else begin
            taken = 0;
            prev = 0;
            have_prev = 1'b0;
            // link the lowest free entries in ascending order
            for (int unsigned i = 0; i < used && taken < need; i++) begin
              if (chain_next[i] == fca_pkg::FREE_CODE) begin
                if (have_prev) chain_next[prev] = PW'(i);
                else res.pointer = PW'(i);
                prev = i;
                have_prev = 1'b1;
                taken++;
              end
            end
            if (have_prev) chain_next[prev] = fca_pkg::END_CODE;
            free_left = free_left - PW'(taken);
          end
        end
      end
      fca_pkg::KIND_FREE, fca_pkg::KIND_LOOKUP: begin
        if (idx >= used) begin
          res.status = fca_pkg::STAT_RANGE;
        end else if (kind == fca_pkg::KIND_FREE) begin
          cur = idx;
          steps = 0;
          // stop at an entry already free, a pointer off the table, or a runaway loop
          while (cur < used && steps < fca_pkg::MAX_BLOCKS) begin
            nxt = chain_next[cur];
            if (nxt == fca_pkg::FREE_CODE) break;
            chain_next[cur] = fca_pkg::FREE_CODE;
            free_left++;
            cur = nxt;
            steps++;
          end
        end else begin
          res.pointer = chain_next[idx];
        end
      end
      default: ;
    endcase
    res.free_blocks = free_left;
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    fat_result_t want;
    if (!rst_ni) begin
      bytes_per_blk = fca_pkg::BB_W'(8);
      table_size = fca_pkg::CFG_W'(fca_pkg::MAX_BLOCKS);
      clear_chain_table();
      awaited_results.delete();
      outstanding = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == fca_pkg::REG_BLOCK_BYTES) begin
          bytes_per_blk = cfg_data_i[fca_pkg::BB_W-1:0];
        end else begin
          table_size = cfg_data_i;
          clear_chain_table();
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        serve_request(s_axis_tuser, s_axis_tdata[fca_pkg::LEN_W-1:0],
                      s_axis_tdata[fca_pkg::LEN_W+fca_pkg::IDX_W-1:fca_pkg::LEN_W], want);
        awaited_results.insert(awaited_results.size(), want);
        outstanding++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        result_cnt++;
        if (m_axis_tuser == fca_pkg::STAT_NO_SPACE) no_space_cnt++;
        if (m_axis_tuser == fca_pkg::STAT_RANGE) range_cnt++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with no request outstanding, actual status %0d",
                   $time, m_axis_tuser);
          $display("  pointer %0d free %0d",
                   m_axis_tdata[PW-1:0], m_axis_tdata[2*PW-1:PW]);
        end else begin
          want = awaited_results.pop_front();
          outstanding--;
          check_field("status", want.status, m_axis_tuser);
          check_field("pointer", want.pointer, m_axis_tdata[PW-1:0]);
          check_field("free_blocks", want.free_blocks, m_axis_tdata[2*PW-1:PW]);
        end
      end
    end
  end

endmodule

// File: verif/fat_chain_allocator_tb.sv
// Top of the allocator testbench: clock, reset, request and register stimulus, result
// sink and verdict. Depends on fca_pkg, fat_chain_allocator and fca_chk.
`timescale 1ns / 1ps

module fat_chain_allocator_tb;

  localparam logic [1:0]  KIND_UNUSED    = 2'd3;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned POOL_DEPTH     = 64;
  localparam int unsigned PW             = fca_pkg::PTR_W;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;     // length_bytes[11:0], block_index[19:12]
  logic [1:0]  s_axis_tuser = '0;     // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;          // pointer[8:0], free_blocks[17:9]
  logic [1:0]  m_axis_tuser;          // status
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [8:0]  cfg_data_i = '0;

  int mismatches, pending, results, no_space_seen, range_seen;

  int unsigned cur_bytes = 8;
  int unsigned cur_used = 256;
  int unsigned chain_pool [$];        // indices seen in results, used as free heads
  int unsigned requests_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned idle_cycles = 0;
  bit          calm = 1'b0;
  bit          long_hold_req = 1'b0;

  fat_chain_allocator uut (.*);

  fca_chk chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .errors_o(mismatches), .pending_o(pending), .results_o(results),
    .no_space_o(no_space_seen), .range_o(range_seen)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_req(input logic [1:0] kind, input int unsigned len,
                          input int unsigned idx);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, fca_pkg::IDX_W'(idx), fca_pkg::LEN_W'(len)};
    s_axis_tuser <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
  endtask

  // drop valid and hold until every outstanding result has been taken
  task automatic drain_requests();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [8:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    if (idx == fca_pkg::REG_BLOCK_BYTES) begin
      cur_bytes = data[fca_pkg::BB_W-1:0];
    end else begin
      cur_used = (data > fca_pkg::MAX_BLOCKS) ? fca_pkg::MAX_BLOCKS : data;
      chain_pool.delete();
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned r, len, idx, bb, pick;
    logic [1:0] kind;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      bb = (cur_bytes == 0) ? 1 : cur_bytes;
      if (r < 40) kind = fca_pkg::KIND_ALLOC;
      else if (r < 70) kind = fca_pkg::KIND_FREE;
      else if (r < 95) kind = fca_pkg::KIND_LOOKUP;
      else kind = KIND_UNUSED;
      // lengths mostly of a few blocks, now and then anything
      if ($urandom_range(0, 6) == 0) len = $urandom_range(0, 4095);
      else len = $urandom_range(0, (bb * 8 > 4095) ? 4095 : bb * 8);
      if (kind == fca_pkg::KIND_FREE && chain_pool.size() != 0 &&
          $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, chain_pool.size() - 1);
        idx = chain_pool[pick];
        chain_pool.delete(pick);
      end else if (cur_used != 0 && $urandom_range(0, 5) != 0) begin
        idx = $urandom_range(0, cur_used - 1);
      end else begin
        idx = $urandom_range(0, 255);
      end
      send_req(kind, len, idx);
    end
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready && m_axis_tdata[PW-1:0] < fca_pkg::END_CODE) begin
      chain_pool.insert(chain_pool.size(), m_axis_tdata[PW-1:0]);
      if (chain_pool.size() > POOL_DEPTH) void'(chain_pool.pop_front());
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned hold;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else begin
        hold = pick_gap();
        if (hold == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat (hold - 1) @(negedge clk_i);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: eight bytes per block, full table
    send_req(fca_pkg::KIND_ALLOC, 0, 0);          // zero length
    send_req(fca_pkg::KIND_LOOKUP, 0, 0);         // entry never written reads free
    send_req(fca_pkg::KIND_ALLOC, 4095, 255);     // far more blocks than the table holds
    send_req(fca_pkg::KIND_ALLOC, 1, 0);
    send_req(fca_pkg::KIND_ALLOC, 17, 0);
    send_req(fca_pkg::KIND_LOOKUP, 0, 1);
    send_req(fca_pkg::KIND_LOOKUP, 0, 3);
    send_req(fca_pkg::KIND_FREE, 0, 1);
    send_req(fca_pkg::KIND_FREE, 0, 1);           // head already free
    send_req(fca_pkg::KIND_ALLOC, 24, 0);
    send_req(fca_pkg::KIND_FREE, 0, 2);           // tail of a chain only
    send_req(fca_pkg::KIND_FREE, 0, 1);           // walk halts at the freed tail
    send_req(KIND_UNUSED, 4095, 255);
    send_req(fca_pkg::KIND_ALLOC, 2041, 0);       // one block short
    send_req(fca_pkg::KIND_ALLOC, 2040, 0);       // takes every free entry
    send_req(fca_pkg::KIND_LOOKUP, 0, 255);
    send_req(fca_pkg::KIND_ALLOC, 1, 0);
    send_req(fca_pkg::KIND_FREE, 0, 1);
    send_req(fca_pkg::KIND_FREE, 0, 0);
    send_req(fca_pkg::KIND_ALLOC, 2048, 0);       // whole table in one chain
    send_req(fca_pkg::KIND_LOOKUP, 0, 254);
    send_req(fca_pkg::KIND_FREE, 0, 0);
    send_req(fca_pkg::KIND_LOOKUP, 4095, 255);
    drain_requests();

    write_reg(fca_pkg::REG_BLOCK_BYTES, 9'd64);
    write_reg(fca_pkg::REG_BLOCKS_IN_USE, 9'd256);
    run_random(30);
    long_hold_req = 1'b1;
    run_random(120);
    drain_requests();

    write_reg(fca_pkg::REG_BLOCK_BYTES, 9'd1);
    write_reg(fca_pkg::REG_BLOCKS_IN_USE, 9'd16);
    run_random(75);
    drain_requests();
    run_random(75);
    drain_requests();

    write_reg(fca_pkg::REG_BLOCK_BYTES, 9'd0);
    write_reg(fca_pkg::REG_BLOCKS_IN_USE, 9'd1);
    calm = 1'b1;
    run_random(50);
    calm = 1'b0;
    drain_requests();

    write_reg(fca_pkg::REG_BLOCK_BYTES, 9'd127);
    write_reg(fca_pkg::REG_BLOCKS_IN_USE, 9'd300);
    run_random(100);
    drain_requests();

    write_reg(fca_pkg::REG_BLOCK_BYTES, 9'd13);
    write_reg(fca_pkg::REG_BLOCKS_IN_USE, 9'd0);
    run_random(30);
    drain_requests();

    // upper data bits of the block size write are dropped by the register
    write_reg(fca_pkg::REG_BLOCKS_IN_USE, 9'($urandom_range(1, 256)));
    write_reg(fca_pkg::REG_BLOCK_BYTES,
              {2'($urandom_range(0, 3)), 7'($urandom_range(1, 64))});
    calm = 1'b1;
    run_random(80);
    calm = 1'b0;
    run_random(170);
    drain_requests();

    repeat (300) @(posedge clk_i);
    $display("Sent %0d requests across %0d register writes; %0d results checked,",
             requests_sent, reg_writes, results);
    $display("%0d of them out of space and %0d out of range.", no_space_seen, range_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: fat_chain_allocator.f
rtl/fca_pkg.sv
rtl/fca_div.sv
rtl/fat_chain_allocator.sv
rtl/fca_chk.sv
verif/fca_chk.sv
verif/fat_chain_allocator_tb.sv
